/* design/sorted_priority_queue_macros.svh */
// Assertion macros shared by the sorted priority queue modules.
// Each file that asserts includes this header; defining NO_ASSERTIONS empties the macros.
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SPQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define SPQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SPQ_ASSERT_IMP(label, ante, cons, msg)
`define SPQ_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

/* design/spq_pkg.sv */
// Shared types and codes for the sorted priority queue.
// Used by the top level and the output register; depends on nothing.
package spq_pkg;

  typedef enum logic [2:0] {
    OP_PUSH   = 3'd0,
    OP_INSERT = 3'd1,
    OP_POP    = 3'd2,
    OP_PEEK   = 3'd3,
    OP_SORT   = 3'd4,
    OP_READ   = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef struct packed {
    logic [31:0] data;
    status_e     status;
    logic        is_empty;
  } res_t;

endpackage

/* design/spq_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies; contents are undefined until written.
module spq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/spq_out.sv */
// Output register of the sorted priority queue, holding one result request.
// Depends on spq_pkg and the assertion macro header.
`include "sorted_priority_queue_macros.svh"
module spq_out #(
  parameter int CW = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  spq_pkg::res_t       res_i,
  input  logic [CW-1:0]       len_i,
  output logic                free_o,
  output logic                valid_o,
  input  logic                stall_i,
  output logic signed [31:0]  data_o,
  output logic [CW-1:0]       length_o,
  output logic                is_empty_o,
  output logic [1:0]          status_o
);
  import spq_pkg::*;

  logic          valid_q, valid_d;
  res_t          res_q;
  logic [CW-1:0] len_q;

  assign free_o  = !valid_q || !stall_i;
  assign valid_d = load_i || (valid_q && stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
      len_q <= len_i;
    end
  end

  assign valid_o    = valid_q;
  assign data_o     = res_q.data;
  assign length_o   = len_q;
  assign is_empty_o = res_q.is_empty;
  assign status_o   = res_q.status;

  `SPQ_ASSERT_IMP(a_load_free, load_i, !valid_q || !stall_i, "result loaded over a held result")

endmodule

/* design/sorted_priority_queue.sv */
// Push, pop, unused codes and flagged requests: result loaded into the output register on
// acceptance, next request taken once that register is free. Peek and read position: through the
// read state. Priority insert at position p of n entries: scan up to p, then shift down to p,
// then write. Sort of n entries: n - 1 passes. The steps follow from the single read/write port
// of the entry memory. Reset clears count, ring base and sequencer; the memory is not cleared.
`include "sorted_priority_queue_macros.svh"
module sorted_priority_queue #(
  parameter int DEPTH = 16,
  parameter int DATA_WIDTH = 32,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic [2:0]         op_i,
  input  logic signed [31:0] value_i,
  input  logic [3:0]         index_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic signed [31:0] data_o,
  output logic [CW-1:0]      length_o,
  output logic               is_empty_o,
  output logic [1:0]         status_o
);
  import spq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int IW = (CW > 4) ? CW : 4;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_PUT   = 3'd4;
  localparam logic [2:0] S_SORT  = 3'd5;
  localparam logic [2:0] S_SFIN  = 3'd6;

  logic [2:0]            state_q, state_d;
  logic [CW-1:0]         count_q, count_d;
  logic [AW-1:0]         base_q, base_d;
  logic [CW-1:0]         pass_q, pass_d;
  logic [AW-1:0]         sk_q, sk_d;
  logic [AW-1:0]         pos_q, pos_d;
  logic [DATA_WIDTH-1:0] val_q, val_d;
  logic [DATA_WIDTH-1:0] carry_q, carry_d;

  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

  logic                  out_load, out_free;
  res_t                  out_res;

  logic                  in_acc, full;
  logic [AW-1:0]         cnt_m1;
  logic [DATA_WIDTH-1:0] val_in;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base, input logic [AW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= (AW + 1)'(DEPTH)) begin
      s = s - (AW + 1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  function automatic logic less(input logic [DATA_WIDTH-1:0] a, input logic [DATA_WIDTH-1:0] b);
    return $signed(a) < $signed(b);
  endfunction

  assign stall_o = (state_q != S_IDLE) || !out_free;
  assign in_acc  = valid_i && !stall_o;
  assign full    = (count_q == CW'(DEPTH));
  assign cnt_m1  = AW'(count_q - 1'b1);
  assign val_in  = DATA_WIDTH'($unsigned(value_i));

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    base_d    = base_q;
    pass_d    = pass_q;
    sk_d      = sk_q;
    pos_d     = pos_q;
    val_d     = val_q;
    carry_d   = carry_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = '0;
    ram_raddr = '0;
    ram_wdata = val_q;
    out_load  = 1'b0;
    out_res   = '{data: '0, status: ST_OK, is_empty: 1'b0};

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          val_d = val_in;
          unique case (op_e'(op_i))
            OP_PUSH: begin
              out_load = 1'b1;
              if (full) begin
                out_res.status = ST_FULL;
              end else begin
                base_d    = (base_q == '0) ? AW'(DEPTH - 1) : AW'(base_q - 1'b1);
                ram_we    = 1'b1;
                ram_waddr = base_d;
                ram_wdata = val_in;
                count_d   = count_q + 1'b1;
              end
            end
            OP_INSERT: begin
              if (full) begin
                out_load       = 1'b1;
                out_res.status = ST_FULL;
              end else if (count_q == '0) begin
                pos_d   = '0;
                state_d = S_PUT;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = base_q;
                sk_d      = '0;
                state_d   = S_SCAN;
              end
            end
            OP_POP: begin
              out_load = 1'b1;
              if (count_q == '0) begin
                out_res.status = ST_EMPTY;
              end else begin
                count_d = count_q - 1'b1;
              end
            end
            OP_PEEK: begin
              if (count_q == '0) begin
                out_load       = 1'b1;
                out_res.status = ST_EMPTY;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = phys(base_q, cnt_m1);
                state_d   = S_RD;
              end
            end
            OP_SORT: begin
              if (count_q < CW'(2)) begin
                out_load = 1'b1;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = base_q;
                sk_d      = '0;
                pass_d    = count_q - 1'b1;
                state_d   = S_SORT;
              end
            end
            OP_READ: begin
              if (IW'(index_i) >= IW'(count_q)) begin
                out_load       = 1'b1;
                out_res.status = ST_RANGE;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = phys(base_q, AW'(index_i));
                state_d   = S_RD;
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      S_RD: begin
        out_load     = 1'b1;
        out_res.data = 32'(ram_rdata);
        state_d      = S_IDLE;
      end
      S_SCAN: begin
        if (less(ram_rdata, val_q)) begin
          pos_d     = sk_q;
          ram_re    = 1'b1;
          ram_raddr = phys(base_q, cnt_m1);
          sk_d      = cnt_m1;
          state_d   = S_SHIFT;
        end else if (CW'(sk_q) + 1'b1 == count_q) begin
          pos_d   = AW'(count_q);
          state_d = S_PUT;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = phys(base_q, AW'(sk_q + 1'b1));
          sk_d      = AW'(sk_q + 1'b1);
        end
      end
      S_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = phys(base_q, AW'(sk_q + 1'b1));
        ram_wdata = ram_rdata;
        if (sk_q == pos_q) begin
          state_d = S_PUT;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = phys(base_q, AW'(sk_q - 1'b1));
          sk_d      = AW'(sk_q - 1'b1);
        end
      end
      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = phys(base_q, pos_q);
        ram_wdata = val_q;
        count_d   = count_q + 1'b1;
        out_load  = 1'b1;
        state_d   = S_IDLE;
      end
      S_SORT: begin
        if (sk_q == '0) begin
          carry_d = ram_rdata;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = phys(base_q, AW'(sk_q - 1'b1));
          if (less(carry_q, ram_rdata)) begin
            ram_wdata = ram_rdata;
          end else begin
            ram_wdata = carry_q;
            carry_d   = ram_rdata;
          end
        end
        if (sk_q == cnt_m1) begin
          state_d = S_SFIN;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = phys(base_q, AW'(sk_q + 1'b1));
          sk_d      = AW'(sk_q + 1'b1);
        end
      end
      S_SFIN: begin
        ram_we    = 1'b1;
        ram_waddr = phys(base_q, cnt_m1);
        ram_wdata = carry_q;
        if (pass_q == CW'(1)) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end else begin
          pass_d    = pass_q - 1'b1;
          ram_re    = 1'b1;
          ram_raddr = base_q;
          sk_d      = '0;
          state_d   = S_SORT;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    out_res.is_empty = (count_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      base_q  <= '0;
      pass_q  <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      base_q  <= base_d;
      pass_q  <= pass_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sk_q    <= sk_d;
    pos_q   <= pos_d;
    val_q   <= val_d;
    carry_q <= carry_d;
  end

  spq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  spq_out #(
    .CW (CW)
  ) u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (out_load),
    .res_i      (out_res),
    .len_i      (count_d),
    .free_o     (out_free),
    .valid_o    (valid_o),
    .stall_i    (stall_i),
    .data_o     (data_o),
    .length_o   (length_o),
    .is_empty_o (is_empty_o),
    .status_o   (status_o)
  );

  `SPQ_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CW'(DEPTH), "entry count exceeds depth")
  `SPQ_ASSERT_IMP(a_rw_apart, ram_we && ram_re, ram_waddr != ram_raddr, "read and write collide")
  `SPQ_ASSERT_IMP(a_base_push, base_q != $past(base_q), count_q == $past(count_q) + 1'b1, "base moved without a push")
  `SPQ_ASSERT_NXT(a_pop_count, in_acc && op_i == OP_POP && count_q != '0, count_q == $past(count_q) - 1'b1, "pop did not shorten the queue")
  `SPQ_ASSERT_IMP(a_sort_pass, state_q == S_SORT || state_q == S_SFIN, pass_q != '0, "sort running with no pass left")

endmodule
